>>> hw/rtl/ist_pkg.sv
`default_nettype none
package ist_pkg;

    // Table depth and derived widths.
    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 5;

    // Request codes; the unused code behaves as a lookup.
    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_SPARE  = 2'd3
    } req_type_t;

    // Strobes that the sequencer sends to every cell of the row.
    typedef struct packed {
        logic cap_en;    // register the per-cell compare
        logic shift_en;  // cells at and above the hit take their neighbor's key
        logic load_en;   // the cell at the fill position takes the request key
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/ist_if.sv
`default_nettype none
// Request channel: one lookup, insert or delete per item.
interface ist_req_if;
    import ist_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [KEY_W-1:0]  key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

// Response channel: one item for each request.
interface ist_rsp_if;
    import ist_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 was_member;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 full_drop;

    modport source (output valid, output was_member, output entry_count,
                    output full_drop, input ready);
    modport sink   (input valid, input was_member, input entry_count,
                    input full_drop, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ist_cell.sv
`default_nettype none
// One table entry: holds a key, compares it with the request, takes the key
// on append, or its upper neighbor's key when it or a lower entry is deleted.
module ist_cell (
    input  wire logic                         clk,
    input  wire ist_pkg::cell_ctl_t           ctl,
    input  wire logic                         valid,
    input  wire logic                         append_sel,
    input  wire logic [ist_pkg::KEY_W-1:0]    req_key,
    input  wire logic [ist_pkg::KEY_W-1:0]    nbr_key,
    input  wire logic                         seen_in,
    output logic [ist_pkg::KEY_W-1:0]         key,
    output logic                              hit,
    output logic                              seen_out
);
    import ist_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic             hit_reg;

    // Compare stage: only entries in use can match.
    always_ff @(posedge clk)
    begin
        if (ctl.cap_en)
        begin
            hit_reg <= valid && (key_reg == req_key);
        end
    end

    // A hit here or in any lower cell marks this cell as part of the shift.
    assign seen_out = seen_in | hit_reg;

    // Entry update: shift down on delete, or take the key on append.
    always_ff @(posedge clk)
    begin
        if (ctl.shift_en && seen_out)
        begin
            key_reg <= nbr_key;
        end
        else if (ctl.load_en && append_sel)
        begin
            key_reg <= req_key;
        end
    end

    assign key = key_reg;
    assign hit = hit_reg;

endmodule
`default_nettype wire

>>> hw/rtl/integer_set_table_core.sv
`default_nettype none
// Set of signed 32-bit keys kept in an unordered table of CAPACITY entries.
// The req channel carries one item per request: req_type selects lookup (0),
// insert (1) or delete (2); code 3 acts as a lookup. The rsp channel returns
// exactly one item per request, in order: was_member (key present before the
// request), entry_count (keys held afterwards, low five bits) and full_drop
// (an insert of an absent key found the table full and was dropped).
// Each request passes the row of entry cells in a compare step, which registers
// every cell's compare, and an update step, which combines the hits along the
// row and updates the entries and the count. The response is registered when
// the update step commits. A new request can be taken in the update step of
// the previous one, as it commits, but not during the compare step.
// If rsp is stalled, the finished request waits in its update step until the
// response register frees up, and req is held off meanwhile.
// Reset clears the count and the control state only; entry contents are not
// cleared, since only entries below the count can match.
module integer_set_table_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ist_req_if.sink    req,
    ist_rsp_if.source  rsp
);
    import ist_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  held_count_reg, held_count_next;
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;

    logic                 out_valid_reg;
    logic                 was_member_reg;
    logic [OUT_CNT_W-1:0] entry_count_reg;
    logic                 full_drop_reg;

    logic                 commit;
    logic                 accept;
    logic                 present;
    logic                 full;
    logic                 do_insert;
    logic                 do_delete;
    logic                 dropped;
    cell_ctl_t            ctl;

    logic [KEY_W-1:0]     cell_key  [CAPACITY+1];
    logic [CAPACITY:0]    seen;
    logic [CAPACITY-1:0]  hit;
    logic [CNT_W+OUT_CNT_W-1:0] count_wide;

    // Handshake: take a request when idle or while the previous one commits.
    assign commit = (state_reg == S_UPD) && (!out_valid_reg || rsp.ready);
    assign req.ready = (state_reg == S_IDLE) || commit;
    assign accept = req.valid && req.ready;

    // Request decode in the update cycle.
    assign present   = seen[CAPACITY];
    assign full      = (held_count_reg == CNT_W'(CAPACITY));
    assign do_insert = (op_reg == REQ_INSERT) && !present && !full;
    assign dropped   = (op_reg == REQ_INSERT) && !present && full;
    assign do_delete = (op_reg == REQ_DELETE) && present;

    assign ctl.cap_en   = (state_reg == S_CMP);
    assign ctl.shift_en = commit && do_delete;
    assign ctl.load_en  = commit && do_insert;

    // Row of entry cells; the top neighbor input repeats the last key.
    assign seen[0] = 1'b0;
    assign cell_key[CAPACITY] = cell_key[CAPACITY-1];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ist_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .valid      (held_count_reg > CNT_W'(i)),
            .append_sel (held_count_reg == CNT_W'(i)),
            .req_key    (key_reg),
            .nbr_key    (cell_key[i+1]),
            .seen_in    (seen[i]),
            .key        (cell_key[i]),
            .hit        (hit[i]),
            .seen_out   (seen[i+1])
        );
    end

    // Count after this request.
    always_comb
    begin
        held_count_next = held_count_reg;
        if (do_insert)
        begin
            held_count_next = held_count_reg + CNT_W'(1);
        end
        else if (do_delete)
        begin
            held_count_next = held_count_reg - CNT_W'(1);
        end
    end

    assign count_wide = {{OUT_CNT_W{1'b0}}, held_count_next};

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_CMP;
            S_CMP:   state_next = S_UPD;
            S_UPD:
            begin
                if (commit)
                begin
                    state_next = accept ? S_CMP : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                held_count_reg <= held_count_next;
            end
        end
    end

    // Request holding register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.req_type;
            key_reg <= req.key;
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            was_member_reg  <= present;
            entry_count_reg <= count_wide[OUT_CNT_W-1:0];
            full_drop_reg   <= dropped;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.was_member  = was_member_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.full_drop   = full_drop_reg;

    // Checks.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> $onehot0(hit))
        else $error("key found in more than one entry");

    a_drop_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && full_drop_reg) |-> !was_member_reg)
        else $error("dropped insert reported a present key");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && do_delete) |=> (held_count_reg == $past(held_count_reg) - CNT_W'(1)))
        else $error("delete did not decrement the count");

    a_no_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> !req.ready)
        else $error("request taken during compare cycle");

endmodule
`default_nettype wire
